>>> src/cfpr_pkg.sv
// Package for the framed packet receiver: codes, constants, CRC helper
// and the command/status bundles shared by controller and datapath.
// No dependencies.
package cfpr_pkg;

    // Frame status codes carried on the result channel
    localparam logic [1:0] FS_GOOD    = 2'd0;
    localparam logic [1:0] FS_VERSION = 2'd1;
    localparam logic [1:0] FS_LENGTH  = 2'd2;
    localparam logic [1:0] FS_CRC     = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_START_ONE = 2'd0;
    localparam logic [1:0] REG_START_TWO = 2'd1;
    localparam logic [1:0] REG_VERSION   = 2'd2;

    // Configuration reset values
    localparam logic [7:0] START_ONE_RST = 8'hAA;
    localparam logic [7:0] START_TWO_RST = 8'h55;
    localparam logic [7:0] VERSION_RST   = 8'h01;

    // Frame layout: 2 start bytes + 10 header bytes, then payload, then 2 CRC bytes
    localparam logic [6:0] HDR_BYTES      = 7'd12;
    localparam logic [6:0] OVERHEAD_BYTES = 7'd14;
    localparam int         HDR_STORE      = 10;

    localparam int DEFAULT_MAX_PAYLOAD = 64;

    // CRC16-CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STATUS,
        S_DRAIN
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic take_byte;
        logic load_status;
        logic load_data;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic ev_result;
        logic ev_drain;
        logic drain_last;
    } dp_status_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> src/cfpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> src/cfpr_ctrl.sv
// Request sequencer: takes bytes, queues status results and drains payload.
// Uses cfpr_pkg.
module cfpr_ctrl import cfpr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd.take_byte   = 1'b0;
        cmd.load_status = 1'b0;
        cmd.load_data   = 1'b0;
        in_stall        = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.take_byte = in_valid;
                if (in_valid)
                begin
                    if (sts.ev_result)
                        state_next = S_STATUS;
                    else if (sts.ev_drain)
                        state_next = S_DRAIN;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    cmd.load_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    cmd.load_data = 1'b1;
                    if (sts.drain_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_status || cmd.load_data)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/cfpr_datapath.sv
// Parser datapath: config registers, frame counters, header store, CRC,
// payload RAM and the result register. Uses cfpr_pkg and cfpr_ram.
module cfpr_datapath import cfpr_pkg::*; #(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic [7:0]  rx_byte,
    input  dp_cmd_t     cmd,
    output dp_status_t  sts,
    output logic [1:0]  frame_status,
    output logic        sequence_jump,
    output logic [7:0]  message_id,
    output logic [15:0] payload_length,
    output logic [15:0] sequence_number,
    output logic [31:0] timestamp,
    output logic [7:0]  data_byte,
    output logic        data_valid,
    output logic        last_of_run
);

    localparam int PAW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]  start_one_reg, start_two_reg, version_reg;
    logic [6:0]  idx_reg, idx_next;
    logic [6:0]  flen_reg, flen_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [15:0] prev_seq_reg, prev_seq_next;
    logic        seq_seen_reg, seq_seen_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        res_jump_reg, res_jump_next;
    logic [PAW-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]  hdr_reg [HDR_STORE];

    logic [6:0]  idx_inc;
    logic [15:0] hdr_len, hdr_seq, rx_crc;
    logic [7:0]  pay_lim;
    logic [6:0]  pay_pos;
    logic        hdr_wen, pay_we;
    logic        good, ev_len, ev_end;
    logic [7:0]  ram_q;

    assign hdr_len = {hdr_reg[3], hdr_reg[2]};
    assign hdr_seq = {hdr_reg[5], hdr_reg[4]};
    assign idx_inc = idx_reg + 7'd1;
    assign pay_lim = {1'b0, HDR_BYTES} + {1'b0, hdr_len[6:0]};
    assign pay_pos = idx_reg - HDR_BYTES;
    assign rx_crc  = {rx_byte, crc_lo_reg};

    // Per-byte parse step
    always_comb
    begin
        idx_next        = idx_reg;
        flen_next       = flen_reg;
        crc_next        = crc_reg;
        crc_lo_next     = crc_lo_reg;
        prev_seq_next   = prev_seq_reg;
        seq_seen_next   = seq_seen_reg;
        res_status_next = res_status_reg;
        res_jump_next   = res_jump_reg;
        hdr_wen         = 1'b0;
        pay_we          = 1'b0;
        good            = 1'b0;
        ev_len          = 1'b0;
        ev_end          = 1'b0;
        if (cmd.take_byte)
        begin
            if (flen_reg == 7'd0)
            begin
                if (idx_reg == 7'd0)
                begin
                    if (rx_byte == start_one_reg)
                    begin
                        idx_next = 7'd1;
                        crc_next = CRC_INIT;
                    end
                end
                else if (idx_reg == 7'd1)
                begin
                    if (rx_byte == start_two_reg)
                    begin
                        idx_next = 7'd2;
                        crc_next = CRC_INIT;
                    end
                    else if (rx_byte == start_one_reg)
                        idx_next = 7'd1;
                    else
                        idx_next = 7'd0;
                end
                else
                begin
                    hdr_wen  = 1'b1;
                    crc_next = crc_feed(crc_reg, rx_byte);
                    idx_next = idx_inc;
                    if (idx_inc >= HDR_BYTES)
                    begin
                        if (hdr_len > 16'(MAX_PAYLOAD))
                        begin
                            ev_len          = 1'b1;
                            idx_next        = 7'd0;
                            res_status_next = FS_LENGTH;
                            res_jump_next   = 1'b0;
                        end
                        else
                            flen_next = OVERHEAD_BYTES + hdr_len[6:0];
                    end
                end
            end
            else
            begin
                if ({1'b0, idx_reg} < pay_lim)
                begin
                    pay_we   = 1'b1;
                    crc_next = crc_feed(crc_reg, rx_byte);
                end
                else if ({1'b0, idx_reg} == pay_lim)
                    crc_lo_next = rx_byte;
                idx_next = idx_inc;
                if (idx_inc >= flen_reg)
                begin
                    ev_end        = 1'b1;
                    idx_next      = 7'd0;
                    flen_next     = 7'd0;
                    res_jump_next = 1'b0;
                    if (hdr_reg[0] != version_reg)
                        res_status_next = FS_VERSION;
                    else if (rx_crc != crc_reg)
                        res_status_next = FS_CRC;
                    else
                    begin
                        good            = 1'b1;
                        res_status_next = FS_GOOD;
                        res_jump_next   = seq_seen_reg && (hdr_seq != prev_seq_reg + 16'd1);
                        prev_seq_next   = hdr_seq;
                        seq_seen_next   = 1'b1;
                    end
                end
            end
        end
    end

    assign sts.ev_result  = ev_len || (ev_end && !(good && hdr_len != 16'd0));
    assign sts.ev_drain   = ev_end && good && hdr_len != 16'd0;
    assign sts.drain_last = (16'(rd_idx_reg) + 16'd1) == hdr_len;

    // Drain index: returns to zero after the last byte, so the RAM output
    // already holds entry zero when a drain starts.
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.load_data)
        begin
            if (sts.drain_last)
                rd_idx_next = '0;
            else
                rd_idx_next = rd_idx_reg + PAW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_one_reg  <= START_ONE_RST;
            start_two_reg  <= START_TWO_RST;
            version_reg    <= VERSION_RST;
            idx_reg        <= 7'd0;
            flen_reg       <= 7'd0;
            crc_reg        <= CRC_INIT;
            prev_seq_reg   <= 16'd0;
            seq_seen_reg   <= 1'b0;
            rd_idx_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_ONE: start_one_reg <= cfg_wdata;
                    REG_START_TWO: start_two_reg <= cfg_wdata;
                    REG_VERSION:   version_reg   <= cfg_wdata;
                    default:       ;
                endcase
            end
            idx_reg      <= idx_next;
            flen_reg     <= flen_next;
            crc_reg      <= crc_next;
            prev_seq_reg <= prev_seq_next;
            seq_seen_reg <= seq_seen_next;
            rd_idx_reg   <= rd_idx_next;
        end
    end

    // Registers without reset: CRC low byte, result status and jump, header store
    always_ff @(posedge clk)
    begin
        crc_lo_reg     <= crc_lo_next;
        res_status_reg <= res_status_next;
        res_jump_reg   <= res_jump_next;
        for (int k = 0; k < HDR_STORE; k++)
        begin
            if (hdr_wen && idx_reg == 7'(k + 2))
                hdr_reg[k] <= rx_byte;
        end
    end

    cfpr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_pos[PAW-1:0]),
        .wdata (rx_byte),
        .raddr (rd_idx_next),
        .rdata (ram_q)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_status || cmd.load_data)
        begin
            message_id      <= hdr_reg[1];
            payload_length  <= hdr_len;
            sequence_number <= hdr_seq;
            timestamp       <= {hdr_reg[9], hdr_reg[8], hdr_reg[7], hdr_reg[6]};
            sequence_jump   <= res_jump_reg;
            if (cmd.load_data)
            begin
                frame_status <= FS_GOOD;
                data_byte    <= ram_q;
                data_valid   <= 1'b1;
                last_of_run  <= sts.drain_last;
            end
            else
            begin
                frame_status <= res_status_reg;
                data_byte    <= 8'd0;
                data_valid   <= 1'b0;
                last_of_run  <= 1'b1;
            end
        end
    end

endmodule

>>> src/crc_framed_packet_receiver_top.sv
// Framed packet receiver top: start-byte hunt, header, payload, CRC16 check.
// After the byte that ends a frame is accepted, the result register loads in S_STATUS or,
// byte by byte from the payload RAM read port, in S_DRAIN once the output is free; input
// stalls in both. Bytes are taken one per cycle in S_IDLE, while no result is due.
// Reset (rst_n, async, active low) returns to the hunt, restores default
// start bytes and version, and clears the sequence history. Uses cfpr_pkg.
module crc_framed_packet_receiver_top import cfpr_pkg::*; #(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    // byte requests in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result requests out
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  frame_status,
    output logic        sequence_jump,
    output logic [7:0]  message_id,
    output logic [15:0] payload_length,
    output logic [15:0] sequence_number,
    output logic [31:0] timestamp,
    output logic [7:0]  data_byte,
    output logic        data_valid,
    output logic        last_of_run
);

    // Controller issues take/load commands; datapath reports frame events
    // and whether the current drain entry is the final payload byte.
    dp_cmd_t    cmd;
    dp_status_t sts;

    cfpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath holds config, parse counters, header, CRC, payload RAM and
    // the result register that parts the input side from the output side.
    cfpr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .rx_byte         (rx_byte),
        .cmd             (cmd),
        .sts             (sts),
        .frame_status    (frame_status),
        .sequence_jump   (sequence_jump),
        .message_id      (message_id),
        .payload_length  (payload_length),
        .sequence_number (sequence_number),
        .timestamp       (timestamp),
        .data_byte       (data_byte),
        .data_valid      (data_valid),
        .last_of_run     (last_of_run)
    );

`ifndef SYNTHESIS
    // A byte never raises both a status-only result and a payload drain
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_byte |-> !(sts.ev_result && sts.ev_drain))
        else $error("status and drain raised together");

    // Result register only reloaded when it is empty or being emptied
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_status || cmd.load_data) |-> (!out_valid || !out_stall))
        else $error("result register overwritten");

    // Payload bytes only ever belong to good frames
    a_data_good: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && data_valid) |-> (frame_status == FS_GOOD))
        else $error("payload byte on a failed frame");

    // Status-only results close their run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !data_valid) |-> last_of_run)
        else $error("status-only result not last");
`endif

endmodule

>>> dv/tb.sv
// Self-checking bench for crc_framed_packet_receiver_top: serial byte requests in,
// frame status and payload requests out, checked against a local frame parser model.
// Depends on cfpr_pkg and the receiver RTL only.
`timescale 1ns / 100ps

module tb;
    import cfpr_pkg::*;

    localparam int          MAX_PAY      = DEFAULT_MAX_PAYLOAD;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int          QUIET_CYCLES = 12;
    localparam int          HOLD_CYCLES  = 400;
    // index 3 is not a register: writes to it must be ignored
    localparam logic [1:0]  REG_UNUSED   = 2'd3;

    typedef enum int {
        UK_GOOD,
        UK_BAD_VER,
        UK_BAD_CRC,
        UK_BAD_BOTH,
        UK_TOO_LONG,
        UK_SOF_MISS,
        UK_SOF_REPEAT,
        UK_CORRUPT,
        UK_TRUNC,
        UK_NOISE
    } unit_kind_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        jump;
        logic [7:0]  msg;
        logic [15:0] len;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  data;
        logic        dvalid;
        logic        last;
    } rx_result_t;

    typedef struct {
        unit_kind_t  kind;
        logic [7:0]  msg;
        logic [15:0] len;
        logic [15:0] seq;
        logic [31:0] ts;
        logic        typed;
        logic [1:0]  status;
    } dir_row_t;

    typedef struct {
        logic [7:0] sof1;
        logic [7:0] sof2;
        logic [7:0] ver;
        int         idle;
        int         stall;
    } phase_cfg_t;

    // ---------------------------------------------------------------
    // Clock, reset and DUT
    // ---------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_START_ONE;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  frame_status;
    logic        sequence_jump;
    logic [7:0]  message_id;
    logic [15:0] payload_length;
    logic [15:0] sequence_number;
    logic [31:0] timestamp;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last_of_run;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    crc_framed_packet_receiver_top #(
        .MAX_PAYLOAD (MAX_PAY)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_status    (frame_status),
        .sequence_jump   (sequence_jump),
        .message_id      (message_id),
        .payload_length  (payload_length),
        .sequence_number (sequence_number),
        .timestamp       (timestamp),
        .data_byte       (data_byte),
        .data_valid      (data_valid),
        .last_of_run     (last_of_run)
    );

    // ---------------------------------------------------------------
    // Frame parser model: own copy of parser state and registers.
    // Stores (header, payload) are only read after the current frame
    // has written them, so they start undefined.
    // ---------------------------------------------------------------
    logic [7:0]  cfg_sof1      = START_ONE_RST;
    logic [7:0]  cfg_sof2      = START_TWO_RST;
    logic [7:0]  cfg_ver       = VERSION_RST;
    logic [6:0]  fr_pos        = '0;   // byte position within the frame
    logic [6:0]  fr_len        = '0;   // total frame bytes, 0 until header done
    logic [7:0]  fr_hdr [HDR_STORE];
    logic [15:0] fr_crc        = CRC_INIT;
    logic [7:0]  fr_crc_lo;
    logic [7:0]  fr_payload [MAX_PAY];
    logic [15:0] last_good_seq = '0;
    logic        good_seq_seen = 1'b0;

    rx_result_t  due_results [$];      // results still owed by the DUT, oldest first
    int          mismatches = 0;

    // CRC16-CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = acc ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        return c;
    endfunction

    // header fields always come from the frame that has just ended
    function automatic void queue_result(input logic [1:0] st, input logic jmp,
                                         input logic [7:0] d, input logic dv, input logic lst);
        rx_result_t r;
        r.status = st;
        r.jump   = jmp;
        r.msg    = fr_hdr[1];
        r.len    = {fr_hdr[3], fr_hdr[2]};
        r.seq    = {fr_hdr[5], fr_hdr[4]};
        r.ts     = {fr_hdr[9], fr_hdr[8], fr_hdr[7], fr_hdr[6]};
        r.data   = d;
        r.dvalid = dv;
        r.last   = lst;
        due_results.push_back(r);
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [15:0] plen;
        logic [15:0] rx_crc;
        logic [15:0] seqn;
        logic        jmp;
        int          pos;
        int          n;
        plen = {fr_hdr[3], fr_hdr[2]};
        if (fr_len == '0)
        begin
            if (fr_pos == 7'd0)
            begin
                if (b == cfg_sof1)
                begin
                    fr_pos = 7'd1;
                    fr_crc = CRC_INIT;
                end
            end
            else if (fr_pos == 7'd1)
            begin
                if (b == cfg_sof2)
                begin
                    fr_pos = 7'd2;
                    fr_crc = CRC_INIT;
                end
                else
                begin
                    // resync; a repeated first start byte opens a new hunt
                    fr_pos = (b == cfg_sof1) ? 7'd1 : 7'd0;
                    fr_len = '0;
                end
            end
            else
            begin
                fr_hdr[fr_pos - 7'd2] = b;
                fr_crc = crc16_next(fr_crc, b);
                fr_pos = fr_pos + 7'd1;
                if (fr_pos >= HDR_BYTES)
                begin
                    plen = {fr_hdr[3], fr_hdr[2]};
                    if (plen > 16'(MAX_PAY))
                    begin
                        queue_result(FS_LENGTH, 1'b0, 8'h00, 1'b0, 1'b1);
                        fr_pos = '0;
                        fr_len = '0;
                    end
                    else
                        fr_len = OVERHEAD_BYTES + 7'(plen);
                end
            end
        end
        else
        begin
            pos = int'(fr_pos);
            if (pos < HDR_BYTES + plen)
            begin
                fr_payload[pos - HDR_BYTES] = b;
                fr_crc = crc16_next(fr_crc, b);
            end
            else if (pos == HDR_BYTES + plen)
                fr_crc_lo = b;
            fr_pos = fr_pos + 7'd1;
            if (fr_pos >= fr_len)
            begin
                rx_crc = {b, fr_crc_lo};
                fr_pos = '0;
                fr_len = '0;
                // version is checked before the CRC
                if (fr_hdr[0] != cfg_ver)
                    queue_result(FS_VERSION, 1'b0, 8'h00, 1'b0, 1'b1);
                else if (rx_crc != fr_crc)
                    queue_result(FS_CRC, 1'b0, 8'h00, 1'b0, 1'b1);
                else
                begin
                    seqn = {fr_hdr[5], fr_hdr[4]};
                    jmp = good_seq_seen && (seqn != last_good_seq + 16'd1);
                    last_good_seq = seqn;
                    good_seq_seen = 1'b1;
                    if (plen == 16'd0)
                        queue_result(FS_GOOD, jmp, 8'h00, 1'b0, 1'b1);
                    else
                        for (n = 0; n < plen; n++)
                            queue_result(FS_GOOD, jmp, fr_payload[n], 1'b1, n + 1 == plen);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result checking: each accepted result request against the oldest
    // expectation, field by field.
    // ---------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_monitor
        rx_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t ns: result request with nothing expected, actual status %0h data %0h",
                         $time, frame_status, data_byte);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("frame_status", 32'(want.status), 32'(frame_status));
                check_field("sequence_jump", 32'(want.jump), 32'(sequence_jump));
                check_field("message_id", 32'(want.msg), 32'(message_id));
                check_field("payload_length", 32'(want.len), 32'(payload_length));
                check_field("sequence_number", 32'(want.seq), 32'(sequence_number));
                check_field("timestamp", want.ts, timestamp);
                check_field("data_byte", 32'(want.data), 32'(data_byte));
                check_field("data_valid", 32'(want.dvalid), 32'(data_valid));
                check_field("last_of_run", 32'(want.last), 32'(last_of_run));
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver back-pressure. A long hold, when requested, is counted
    // down here; otherwise stall at the phase's rate.
    // ---------------------------------------------------------------
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    phase_cfg_t  gen_cfg = '{START_ONE_RST, START_TWO_RST, VERSION_RST, 0, 0};
    logic [7:0]  tx_bytes [$];
    logic [15:0] gen_seq = '0;
    int          phase_bytes = 0;

    // Directed frames. Expected results are typed in only for status-only
    // outcomes whose fields come straight from the row.
    dir_row_t dir_rows [18] = '{
        '{UK_GOOD,       8'h00, 16'd0,      16'h0001, 32'h0000_0000, 1'b1, FS_GOOD},
        '{UK_NOISE,      8'h00, 16'd4,      16'h0000, 32'h0000_0000, 1'b0, FS_GOOD},
        '{UK_GOOD,       8'hFF, 16'd1,      16'h0002, 32'hFFFF_FFFF, 1'b0, FS_GOOD},
        '{UK_SOF_MISS,   8'h12, 16'd2,      16'h0003, 32'h0000_0001, 1'b0, FS_GOOD},
        '{UK_SOF_REPEAT, 8'h34, 16'd3,      16'h0004, 32'h8000_0000, 1'b0, FS_GOOD},
        '{UK_TOO_LONG,   8'h56, 16'd65,     16'h0005, 32'h1234_5678, 1'b1, FS_LENGTH},
        '{UK_TOO_LONG,   8'hFF, 16'hFFFF,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, FS_LENGTH},
        '{UK_BAD_VER,    8'h78, 16'd2,      16'h0006, 32'hDEAD_BEEF, 1'b1, FS_VERSION},
        '{UK_BAD_CRC,    8'h9A, 16'd2,      16'h0007, 32'h0BAD_C0DE, 1'b1, FS_CRC},
        '{UK_BAD_BOTH,   8'hBC, 16'd1,      16'h0008, 32'h0000_FFFF, 1'b1, FS_VERSION},
        '{UK_GOOD,       8'hDE, 16'(MAX_PAY), 16'h0005, 32'h0102_0304, 1'b0, FS_GOOD},
        '{UK_GOOD,       8'h01, 16'd4,      16'h0100, 32'hFFFF_0000, 1'b0, FS_GOOD},
        '{UK_GOOD,       8'h80, 16'd0,      16'hFFFF, 32'h7FFF_FFFF, 1'b0, FS_GOOD},
        '{UK_GOOD,       8'h7F, 16'd1,      16'h0000, 32'h0000_0080, 1'b0, FS_GOOD},
        '{UK_TRUNC,      8'h11, 16'd5,      16'h0001, 32'h1111_1111, 1'b0, FS_GOOD},
        '{UK_GOOD,       8'hA5, 16'd2,      16'h0001, 32'h8000_0001, 1'b0, FS_GOOD},
        '{UK_GOOD,       8'h5A, 16'd5,      16'h0002, 32'h7FFF_FFFE, 1'b0, FS_GOOD},
        '{UK_GOOD,       8'hC3, 16'd3,      16'h0003, 32'h5555_AAAA, 1'b0, FS_GOOD}
    };

    // Random phases: extremes of the start bytes and version, equal start
    // bytes, and the four idling mixes.
    phase_cfg_t phases [4] = '{
        '{8'hAA, 8'h55, 8'h01,  0,  0},
        '{8'h00, 8'hFF, 8'hFF, 71,  0},
        '{8'hFF, 8'h00, 8'h00,  0, 71},
        '{8'h7E, 8'h7E, 8'h5A, 15, 15}
    };

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_START_ONE: cfg_sof1 = val;
            REG_START_TWO: cfg_sof2 = val;
            REG_VERSION:   cfg_ver  = val;
            default: ;
        endcase
    endtask

    task automatic apply_phase(input phase_cfg_t p);
        write_reg(REG_START_ONE, p.sof1);
        write_reg(REG_START_TWO, p.sof2);
        write_reg(REG_VERSION, p.ver);
        cfg_we    <= 1'b0;
        gen_cfg   = p;
        idle_pct  = p.idle;
        stall_pct = p.stall;
    endtask

    // Builds one unit of serial bytes. For TRUNC, len is the number of
    // header bytes kept; for NOISE, the number of bytes.
    task automatic build_unit(input unit_kind_t kind, input logic [7:0] msg,
                              input logic [15:0] len, input logic [15:0] seq,
                              input logic [31:0] ts);
        logic [7:0]  hdr_b [HDR_STORE];
        logic [7:0]  ver;
        logic [7:0]  b;
        logic [15:0] crc;
        int          i;
        tx_bytes.delete();
        if (kind == UK_NOISE)
        begin
            // never a first start byte, so all of it is dropped
            for (i = 0; i < len; i++)
            begin
                b = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
                if (b == gen_cfg.sof1)
                    b = b ^ 8'h01;
                tx_bytes.push_back(b);
            end
            return;
        end
        if (kind == UK_SOF_MISS)
        begin
            b = 8'($urandom);
            while (b == gen_cfg.sof1 || b == gen_cfg.sof2)
                b = b + 8'd1;
            tx_bytes.push_back(gen_cfg.sof1);
            tx_bytes.push_back(b);
        end
        else if (kind == UK_SOF_REPEAT)
            tx_bytes.push_back(gen_cfg.sof1);
        ver = gen_cfg.ver;
        if (kind == UK_BAD_VER || kind == UK_BAD_BOTH)
            ver = ver ^ 8'($urandom_range(255, 1));
        hdr_b = '{ver, msg, len[7:0], len[15:8], seq[7:0], seq[15:8],
                  ts[7:0], ts[15:8], ts[23:16], ts[31:24]};
        tx_bytes.push_back(gen_cfg.sof1);
        tx_bytes.push_back(gen_cfg.sof2);
        crc = CRC_INIT;
        for (i = 0; i < HDR_STORE; i++)
        begin
            if (kind == UK_TRUNC && i == len)
                return;
            tx_bytes.push_back(hdr_b[i]);
            crc = crc16_next(crc, hdr_b[i]);
        end
        if (kind == UK_TOO_LONG)
            return;
        for (i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            tx_bytes.push_back(b);
            crc = crc16_next(crc, b);
        end
        if (kind == UK_BAD_CRC || kind == UK_BAD_BOTH)
            crc = crc ^ 16'($urandom_range(65535, 1));
        tx_bytes.push_back(crc[7:0]);
        tx_bytes.push_back(crc[15:8]);
        if (kind == UK_CORRUPT)
        begin
            i = $urandom_range(tx_bytes.size() - 1);
            tx_bytes[i] = tx_bytes[i] ^ 8'($urandom_range(255, 1));
        end
    endtask

    // One byte request. Called in the step of a rising edge; returns in the
    // step of the edge that accepted it. With override, what the byte causes
    // is replaced by the typed-in result.
    task automatic offer_byte(input logic [7:0] b, input logic override,
                              input rx_result_t typed_res);
        int n0;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        n0 = due_results.size();
        parse_rx_byte(b);
        if (override)
        begin
            while (due_results.size() > n0)
                void'(due_results.pop_back());
            due_results.push_back(typed_res);
        end
    endtask

    task automatic send_unit(input logic typed, input rx_result_t typed_res);
        int i;
        for (i = 0; i < tx_bytes.size(); i++)
            offer_byte(tx_bytes[i], typed && (i == tx_bytes.size() - 1), typed_res);
        phase_bytes += tx_bytes.size();
    endtask

    // Mostly well-formed frames with random content; the rest are broken
    // or noisy. Small payloads dominate, the maximum turns up now and then.
    task automatic random_unit(input logic force_good);
        unit_kind_t  kind;
        logic [15:0] len;
        logic [15:0] seq;
        int          r;
        r = force_good ? 0 : $urandom_range(99);
        kind = (r < 55) ? UK_GOOD :
               (r < 63) ? UK_BAD_CRC :
               (r < 67) ? UK_BAD_VER :
               (r < 69) ? UK_BAD_BOTH :
               (r < 74) ? UK_TOO_LONG :
               (r < 78) ? UK_SOF_MISS :
               (r < 81) ? UK_SOF_REPEAT :
               (r < 87) ? UK_CORRUPT :
               (r < 93) ? UK_TRUNC : UK_NOISE;
        r = $urandom_range(99);
        len = (r < 90) ? 16'($urandom_range(8)) :
              (r < 97) ? 16'($urandom_range(MAX_PAY - 1, 9)) : 16'(MAX_PAY);
        if (kind == UK_TOO_LONG)
            len = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 16'(MAX_PAY + 1) : 16'hFFFF)
                                           : 16'($urandom_range(65535, MAX_PAY + 1));
        else if (kind == UK_TRUNC)
            len = 16'($urandom_range(HDR_STORE - 1));
        else if (kind == UK_NOISE)
            len = 16'($urandom_range(6, 1));
        seq = ($urandom_range(99) < 85) ? gen_seq + 16'd1 : 16'($urandom);
        if (kind == UK_GOOD || kind == UK_SOF_MISS || kind == UK_SOF_REPEAT)
            gen_seq = seq;
        build_unit(kind, 8'($urandom), len, seq, $urandom);
        send_unit(1'b0, '0);
    endtask

    // stop offering, let every owed result arrive, then the pipeline settle
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        dir_row_t   row;
        rx_result_t typed_res;
        int         i;
        int         ph;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset settings, no idling
        for (i = 0; i < $size(dir_rows); i++)
        begin
            row = dir_rows[i];
            build_unit(row.kind, row.msg, row.len, row.seq, row.ts);
            typed_res.status = row.status;
            typed_res.jump   = 1'b0;
            typed_res.msg    = row.msg;
            typed_res.len    = row.len;
            typed_res.seq    = row.seq;
            typed_res.ts     = row.ts;
            typed_res.data   = 8'h00;
            typed_res.dvalid = 1'b0;
            typed_res.last   = 1'b1;
            send_unit(row.typed, typed_res);
        end
        wait_quiet();

        write_reg(REG_UNUSED, 8'($urandom));
        for (ph = 0; ph < $size(phases); ph++)
        begin
            apply_phase(phases[ph]);
            phase_bytes = 0;
            while (phase_bytes < 12)
                random_unit(1'b0);
            wait_quiet();
        end

        // long receiver hold-off while frames keep coming: the output side
        // backs up and the byte input has to stall
        apply_phase('{START_ONE_RST, START_TWO_RST, VERSION_RST, 0, 0});
        hold_left <= HOLD_CYCLES;
        phase_bytes = 0;
        for (i = 0; i < 2; i++)
            random_unit(1'b1);
        while (phase_bytes < 30)
            random_unit(1'b0);
        wait_quiet();

        if (mismatches == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
